FILE: design/tccw_pkg.sv
package tccw_pkg;

  // operation codes
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_DEC   = 3'd1;
  localparam logic [2:0] OP_HEX   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'b1;
  localparam int unsigned CFG_DATA_W = 4;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam int unsigned TAB_STEP = 4;
  localparam logic [7:0]  RESET_ATTR  = 8'hF0;
  localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};
  localparam logic [3:0]  DEC_BASE = 4'd10;

  // v / 10 == (v * DEC_RECIP) >> DEC_SHIFT for every 32-bit v
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DEC_SHIFT = 35;
  localparam int unsigned DEC_DIGITS = 10;

  // hex print: '0', 'x', then eight nibbles from the top
  localparam logic [3:0] HEX_ZERO_STEP = 4'd0;
  localparam logic [3:0] HEX_X_STEP    = 4'd1;
  localparam logic [3:0] HEX_LAST_STEP = 4'd9;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [10:0] cell_index;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [6:0]  col_now;
    logic [4:0]  row_now;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic put;
    logic dec_mul;
    logic dec_div;
    logic dec_emit;
    logic hex_emit;
    logic sweep;
    logic init_blank;
    logic home;
    logic read;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic q_zero;
    logic dig_last;
    logic hex_last;
    logic sweep_last;
    logic res_free;
  } sts_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < DEC_BASE) begin
      g = CH_ZERO + {4'b0000, d};
    end else begin
      g = CH_A + {4'b0000, d} - {4'b0000, DEC_BASE};
    end
    return g;
  endfunction

endpackage

FILE: design/text_console_cell_writer.sv
// put byte and read cell pass through PUT or READ to DONE; spare ops go straight to DONE
// decimal print: multiply by reciprocal and divide step per digit, then a cell write per digit
// hex print: '0', 'x', eight digits, a cell write per cycle; clear: one cell a cycle, then home
// one screen memory write port: one character a cycle at most; a stalled result holds the input
// rst is synchronous: cursor home, fg 0, bg 15, then a pass blanks all COLUMNS*ROWS cells
// to 0xF020 while cmd_stall stays high; configuration writes are taken during that pass
module text_console_cell_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  tccw_pkg::cmd_item_t             cmd,
  output logic                            res_valid,
  input  logic                            res_stall,
  output tccw_pkg::res_item_t             res,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);

  tccw_pkg::ctl_t ctl;
  tccw_pkg::sts_t sts;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd.op),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: design/tccw_ram.sv
module tccw_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tccw_ctrl.sv
module tccw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic [2:0]        cmd_op,
  output logic              cmd_stall,
  input  tccw_pkg::sts_t    sts,
  output tccw_pkg::ctl_t    ctl
);

  typedef enum logic [9:0] {
    ST_INIT  = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_PUT   = 10'b00_0000_0100,
    ST_DMUL  = 10'b00_0000_1000,
    ST_DDIV  = 10'b00_0001_0000,
    ST_DEMIT = 10'b00_0010_0000,
    ST_HEMIT = 10'b00_0100_0000,
    ST_CLEAR = 10'b00_1000_0000,
    ST_READ  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        // blank the screen once after reset
        ctl.sweep      = 1'b1;
        ctl.init_blank = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.load = 1'b1;
          case (cmd_op)
            tccw_pkg::OP_PUT:   state_next = ST_PUT;
            tccw_pkg::OP_DEC:   state_next = ST_DMUL;
            tccw_pkg::OP_HEX:   state_next = ST_HEMIT;
            tccw_pkg::OP_CLEAR: state_next = ST_CLEAR;
            tccw_pkg::OP_READ:  state_next = ST_READ;
            default:            state_next = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        ctl.put    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DMUL: begin
        ctl.dec_mul = 1'b1;
        state_next  = ST_DDIV;
      end
      ST_DDIV: begin
        ctl.dec_div = 1'b1;
        state_next  = sts.q_zero ? ST_DEMIT : ST_DMUL;
      end
      ST_DEMIT: begin
        ctl.dec_emit = 1'b1;
        if (sts.dig_last) begin
          state_next = ST_DONE;
        end
      end
      ST_HEMIT: begin
        ctl.hex_emit = 1'b1;
        if (sts.hex_last) begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) begin
          ctl.home   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        ctl.read   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.res_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

FILE: design/tccw_datapath.sv
module tccw_datapath #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tccw_pkg::cmd_item_t                  cmd,
  input  tccw_pkg::ctl_t                       ctl,
  output tccw_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output tccw_pkg::res_item_t                  res
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned AW = $clog2(CELL_COUNT);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned RW = $clog2(ROWS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  tccw_pkg::cmd_item_t item;
  logic [3:0]  fg_color;
  logic [3:0]  bg_color;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] row_base;
  logic [AW-1:0] sweep_addr;
  logic [31:0] dec_v;
  logic [63:0] prod;
  logic [3:0]  dig_n;
  logic [3:0]  digit_store [tccw_pkg::DEC_DIGITS];
  logic [31:0] hex_sh;
  logic [3:0]  hex_k;

  logic [7:0]  attr;
  logic [AW-1:0] cell_addr;
  logic [31:0] dec_q;
  logic [31:0] dec_rem;
  logic [3:0]  dig_idx;
  logic [7:0]  dec_char;
  logic [7:0]  hex_char;
  logic [7:0]  glyph_char;
  logic        is_nul, is_nl, is_cr, is_tab;
  logic        do_glyph, do_nl, do_cr, do_tab;
  logic [CW:0] tab_sum;
  logic        tab_wrap;
  logic        new_row;
  logic        in_range;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0] ram_wdata;
  logic [15:0] ram_q;

  assign attr      = {bg_color, fg_color};
  assign cell_addr = row_base + AW'(col);

  // one decimal digit: quotient by reciprocal, remainder by shift-add
  assign dec_q   = 32'(prod[63:tccw_pkg::DEC_SHIFT]);
  assign dec_rem = dec_v - ((dec_q << 3) + (dec_q << 1));

  assign dig_idx  = dig_n - 4'd1;
  assign dec_char = tccw_pkg::CH_ZERO + {4'b0000, digit_store[dig_idx]};

  always_comb begin
    if (hex_k == tccw_pkg::HEX_ZERO_STEP) begin
      hex_char = tccw_pkg::CH_ZERO;
    end else if (hex_k == tccw_pkg::HEX_X_STEP) begin
      hex_char = tccw_pkg::CH_X;
    end else begin
      hex_char = tccw_pkg::hex_glyph(hex_sh[31:28]);
    end
  end

  always_comb begin
    if (ctl.put) begin
      glyph_char = item.char_code;
    end else if (ctl.dec_emit) begin
      glyph_char = dec_char;
    end else begin
      glyph_char = hex_char;
    end
  end

  assign is_nul = (item.char_code == tccw_pkg::CH_NUL);
  assign is_nl  = (item.char_code == tccw_pkg::CH_NL);
  assign is_cr  = (item.char_code == tccw_pkg::CH_CR);
  assign is_tab = (item.char_code == tccw_pkg::CH_TAB);

  assign do_glyph = (ctl.put && !is_nul && !is_nl && !is_cr && !is_tab)
                    || ctl.dec_emit || ctl.hex_emit;
  assign do_nl  = ctl.put && is_nl;
  assign do_cr  = ctl.put && is_cr;
  assign do_tab = ctl.put && is_tab;

  assign tab_sum  = {1'b0, col} + (CW+1)'(tccw_pkg::TAB_STEP);
  assign tab_wrap = (tab_sum >= (CW+1)'(COLUMNS));
  assign new_row  = (do_glyph && col == LAST_COL) || do_nl || (do_tab && tab_wrap);

  // cursor and the address of the start of its row
  always_ff @(posedge clk) begin
    if (rst || ctl.home) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (new_row) begin
      col <= '0;
      if (row == LAST_ROW) begin
        row      <= '0;
        row_base <= '0;
      end else begin
        row      <= row + 1'b1;
        row_base <= row_base + ROW_STEP;
      end
    end else if (do_glyph) begin
      col <= col + 1'b1;
    end else if (do_tab) begin
      col <= tab_sum[CW-1:0];
    end else if (do_cr) begin
      col <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 4'h0;
      bg_color <= 4'hF;
    end else if (cfg_we) begin
      case (cfg_index)
        tccw_pkg::CFG_FG_COLOR: fg_color <= cfg_data;
        tccw_pkg::CFG_BG_COLOR: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sts.sweep_last = (sweep_addr == LAST_CELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctl.sweep) begin
      sweep_addr <= sts.sweep_last ? '0 : sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dec_v <= cmd.number;
    end else if (ctl.dec_div) begin
      dec_v <= dec_q;
    end
    if (ctl.dec_mul) begin
      prod <= 64'(dec_v) * 64'(tccw_pkg::DEC_RECIP);
    end
    if (ctl.dec_div) begin
      digit_store[dig_n] <= dec_rem[3:0];
    end
    if (ctl.load) begin
      hex_sh <= cmd.number;
    end else if (ctl.hex_emit && hex_k > tccw_pkg::HEX_X_STEP) begin
      hex_sh <= hex_sh << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      dig_n <= '0;
      hex_k <= '0;
    end else begin
      if (ctl.dec_div) begin
        dig_n <= dig_n + 1'b1;
      end else if (ctl.dec_emit) begin
        dig_n <= dig_n - 1'b1;
      end
      if (ctl.hex_emit) begin
        hex_k <= hex_k + 1'b1;
      end
    end
  end

  assign sts.q_zero   = (dec_q == 32'd0);
  assign sts.dig_last = (dig_n == 4'd1);
  assign sts.hex_last = (hex_k == tccw_pkg::HEX_LAST_STEP);

  always_comb begin
    ram_we    = do_glyph || ctl.sweep;
    ram_waddr = ctl.sweep ? sweep_addr : cell_addr;
    if (ctl.sweep) begin
      ram_wdata = ctl.init_blank ? tccw_pkg::RESET_BLANK : {attr, tccw_pkg::CH_SPACE};
    end else begin
      ram_wdata = {attr, glyph_char};
    end
  end

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.read),
    .raddr (AW'(item.cell_index)),
    .rdata (ram_q)
  );

  assign in_range     = (32'(item.cell_index) < 32'(CELL_COUNT));
  assign sts.res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res.read_cell <= (item.op == tccw_pkg::OP_READ && in_range) ? ram_q : 16'h0000;
      res.col_now   <= 7'(col);
      res.row_now   <= 5'(row);
    end
  end

endmodule

FILE: design/tccw_checker.sv
module tccw_checker #(
  parameter int unsigned COLUMNS = 80
) (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input tccw_pkg::res_item_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result dropped or changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second item taken straight after the first");

  // the blanking pass after reset keeps the command channel closed
  a_reset_stall: assert property (@(posedge clk)
    rst |=> cmd_stall)
    else $error("item accepted straight after reset");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.col_now < COLUMNS)
    else $error("cursor column past the line end");

endmodule

bind text_console_cell_writer tccw_checker #(.COLUMNS(COLUMNS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

FILE: tb/tb_top.sv
module tb_top;
  import tccw_pkg::*;

  localparam int unsigned SCR_COLS     = 80;
  localparam int unsigned SCR_ROWS     = 25;
  localparam int unsigned CELLS        = SCR_COLS * SCR_ROWS;
  localparam int unsigned INDEX_MAX    = 2047;
  localparam int unsigned HEX_NIBBLES  = 8;
  localparam logic [7:0]  PRINT_LAST   = 8'h7E;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 255;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned LIMIT_CYCLES = 2000000;

  // screen contents, cursor and colours as the block should hold them,
  // plus the results still owed by the block
  class console_tracker;
    logic [15:0] screen [CELLS];
    int unsigned col, row;
    logic [3:0] fg, bg;
    res_item_t due_results [$];
    int unsigned errors;

    function new();
      foreach (screen[i]) screen[i] = RESET_BLANK;
      col = 0;
      row = 0;
      fg = RESET_ATTR[3:0];
      bg = RESET_ATTR[7:4];
      errors = 0;
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_FG_COLOR) begin
        fg = d;
      end else begin
        bg = d;
      end
    endfunction

    function void next_line();
      col = 0;
      row++;
      if (row >= SCR_ROWS) begin
        row = 0;
      end
    endfunction

    function void glyph(logic [7:0] ch);
      screen[row * SCR_COLS + col] = {bg, fg, ch};
      col++;
      if (col >= SCR_COLS) begin
        next_line();
      end
    endfunction

    function void put_char(logic [7:0] ch);
      case (ch)
        CH_NUL: ;
        CH_NL: next_line();
        CH_CR: col = 0;
        CH_TAB: begin
          col += TAB_STEP;
          if (col >= SCR_COLS) begin
            next_line();
          end
        end
        default: glyph(ch);
      endcase
    endfunction

    function void print_dec(logic [31:0] v);
      logic [3:0] digs [DEC_DIGITS];
      int n;
      n = 0;
      if (v == 0) begin
        glyph(CH_ZERO);
      end else begin
        while (v != 0) begin
          digs[n] = 4'(v % DEC_BASE);
          v = v / DEC_BASE;
          n++;
        end
        while (n > 0) begin
          n--;
          glyph(CH_ZERO + {4'b0000, digs[n]});
        end
      end
    endfunction

    function void show_hex(logic [31:0] v);
      logic [3:0] d;
      put_char(CH_ZERO);
      put_char(CH_X);
      for (int k = HEX_NIBBLES - 1; k >= 0; k--) begin
        d = v[k*4 +: 4];
        if (d < DEC_BASE) begin
          glyph(CH_ZERO + {4'b0000, d});
        end else begin
          glyph(CH_A + {4'b0000, d} - {4'b0000, DEC_BASE});
        end
      end
    endfunction

    function void clear_all();
      logic [15:0] blank;
      blank = {bg, fg, CH_SPACE};
      foreach (screen[i]) screen[i] = blank;
      col = 0;
      row = 0;
    endfunction

    function void take_cmd(cmd_item_t c);
      res_item_t r;
      r.read_cell = '0;
      case (c.op)
        OP_PUT: put_char(c.char_code);
        OP_DEC: print_dec(c.number);
        OP_HEX: show_hex(c.number);
        OP_CLEAR: clear_all();
        OP_READ: begin
          if (c.cell_index < CELLS) begin
            r.read_cell = screen[c.cell_index];
          end
        end
        default: ;
      endcase
      r.col_now = col[6:0];
      r.row_now = row[4:0];
      due_results.push_back(r);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (due_results.size() == 0) begin
        report("unexpected result", 32'd0, 32'(got));
        return;
      end
      want = due_results.pop_front();
      if (got.read_cell !== want.read_cell) begin
        report("read_cell", 32'(want.read_cell), 32'(got.read_cell));
      end
      if (got.col_now !== want.col_now) begin
        report("col_now", 32'(want.col_now), 32'(got.col_now));
      end
      if (got.row_now !== want.row_now) begin
        report("row_now", 32'(want.row_now), 32'(got.row_now));
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_item_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_item_t res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  console_tracker sb;
  int unsigned cmd_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // receiver pattern state
  int unsigned mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  text_console_cell_writer #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      sb.take_cmd(cmd);
      cmd_taken <= cmd_taken + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      sb.check_result(res);
    end
  end

  // receiver: one long hold-off once traffic is flowing, otherwise runs of mixed stalling
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && cmd_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(1, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 99) < 25);
        2: res_stall <= ($urandom_range(0, 99) < 70);
        default: res_stall <= 1'b1;
      endcase
    end
  end

  function automatic cmd_item_t mk(logic [2:0] op, logic [7:0] ch, logic [31:0] num,
                                   logic [10:0] idx);
    cmd_item_t c;
    c.op = op;
    c.char_code = ch;
    c.number = num;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int unsigned r;
    int unsigned s;
    int unsigned here;
    c = mk(OP_PUT, 8'($urandom), $urandom, 11'($urandom));
    r = $urandom_range(0, 99);
    here = sb.row * SCR_COLS + sb.col;
    if (r < 40) begin
      c.char_code = 8'($urandom_range(CH_SPACE, PRINT_LAST));
    end else if (r < 46) begin
      // any byte, high bit included
    end else if (r < 52) begin
      case ($urandom_range(0, 3))
        0: c.char_code = CH_NL;
        1: c.char_code = CH_CR;
        2: c.char_code = CH_TAB;
        default: c.char_code = CH_NUL;
      endcase
    end else if (r < 62) begin
      c.op = OP_DEC;
      c.number = $urandom >> $urandom_range(0, 31);
    end else if (r < 70) begin
      c.op = OP_HEX;
    end else if (r < 94) begin
      c.op = OP_READ;
      s = $urandom_range(0, 9);
      if (s < 6) begin
        // cells just written are the interesting ones
        c.cell_index = 11'((here + CELLS - $urandom_range(1, 160)) % CELLS);
      end else if (s < 9) begin
        c.cell_index = 11'($urandom_range(0, CELLS - 1));
      end else begin
        c.cell_index = 11'($urandom_range(CELLS - 10, INDEX_MAX));
      end
    end else if (r < 97) begin
      c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (r < 98) begin
      c.op = OP_CLEAR;
    end else begin
      c.char_code = 8'($urandom_range(CH_SPACE, PRINT_LAST));
    end
    return c;
  endfunction

  // sender works in bursts with idle gaps between them
  task automatic offer(input cmd_item_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  // step past the current edge first so the last accepted item is already on the scoreboard
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_colours(input logic [3:0] f, input logic [3:0] b);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FG_COLOR;
    cfg_data <= f;
    @(posedge clk);
    cfg_index <= CFG_BG_COLOR;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_colour(CFG_FG_COLOR, f);
    sb.set_colour(CFG_BG_COLOR, b);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset colours
    offer(mk(OP_PUT, CH_A, '0, '0));
    offer(mk(OP_PUT, 8'hFF, '0, '0));
    offer(mk(OP_PUT, CH_NUL, '0, '0));
    offer(mk(OP_PUT, CH_TAB, '0, '0));
    offer(mk(OP_PUT, CH_CR, '0, '0));
    offer(mk(OP_PUT, CH_NL, '0, '0));
    offer(mk(OP_DEC, '0, '0, '0));
    offer(mk(OP_DEC, '0, 32'hFFFF_FFFF, '0));
    offer(mk(OP_HEX, '0, 32'hFFFF_FFFF, '0));
    offer(mk(OP_READ, '0, '0, '0));
    offer(mk(OP_READ, '0, '0, 11'(CELLS - 1)));
    offer(mk(OP_READ, '0, '0, 11'(CELLS)));
    offer(mk(OP_READ, '1, '1, 11'(INDEX_MAX)));
    offer(mk(OP_SPARE_LO, 8'($urandom), $urandom, 11'($urandom)));
    offer(mk(OP_SPARE_HI, 8'($urandom), $urandom, 11'($urandom)));
    offer(mk(OP_CLEAR, '0, '0, '0));
    // seven hex prints leave the cursor at column 70
    for (int k = 0; k < 7; k++) begin
      offer(mk(OP_HEX, '0, (k == 0) ? 32'h0 : $urandom, '0));
    end
    // six digits to column 76, then a tab that runs off the line end
    offer(mk(OP_DEC, '0, 32'd123456, '0));
    offer(mk(OP_PUT, CH_TAB, '0, '0));
    offer(mk(OP_READ, '0, '0, 11'd75));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: write_colours(4'hF, 4'h0);
        1: write_colours(4'h0, 4'h0);
        2: write_colours(4'hF, 4'hF);
        5: write_colours(4'h0, 4'hF);
        default: write_colours(4'($urandom), 4'($urandom));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer(random_cmd());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
